>>> hw/rtl/tpg_pkg.sv
package tpg_pkg;

    localparam int THR_W      = 17;
    localparam int HOV_W      = 16;
    localparam int BOOST_W    = 16;
    localparam int TIME_W     = 32;
    localparam int TMO_W      = 15;
    localparam int STATE_W    = 3;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [TIME_W-1:0] AUTO_TIMEOUT_MS   = 32'd10000;
    localparam logic [TIME_W-1:0] AUTO_MIN_ENTRY_MS = 32'd5000;
    localparam logic [THR_W-1:0]  SPOOL_THRESHOLD   = 17'd21823;
    localparam logic [THR_W-1:0]  OUT_MAX           = 17'h1FFFF;

    // Reset values of the configuration registers
    localparam logic [THR_W-1:0] THROTTLE_CEILING_RST  = 17'd65536;
    localparam logic [HOV_W-1:0] HANDOVER_THROTTLE_RST = 16'd13107;
    localparam logic [TMO_W-1:0] ZERO_TIMEOUT_RST      = 15'd3000;

    typedef enum logic [STATE_W-1:0] {
        ST_OFF,
        ST_IDLE,
        ST_SPOOLUP,
        ST_ACTIVE,
        ST_ZERO,
        ST_AUTO,
        ST_BAILOUT,
        ST_RECOVERY
    } gov_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THROTTLE_CEILING,
        REG_HANDOVER_THROTTLE,
        REG_STARTUP_RATE,
        REG_SPOOLUP_RATE,
        REG_TRACKING_RATE,
        REG_RECOVERY_RATE,
        REG_BAILOUT_RATE,
        REG_ZERO_TIMEOUT
    } cfg_reg_t;

    typedef struct packed {
        logic [THR_W-1:0] throttle_ceiling;
        logic [HOV_W-1:0] handover_throttle;
        logic [THR_W-1:0] startup_rate;
        logic [THR_W-1:0] spoolup_rate;
        logic [THR_W-1:0] tracking_rate;
        logic [THR_W-1:0] recovery_rate;
        logic [THR_W-1:0] bailout_rate;
        logic [TMO_W-1:0] zero_throttle_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic [BOOST_W-1:0] tail_boost;
        logic               is_armed;
        logic               throttle_is_low;
        logic [THR_W-1:0]   throttle_cmd;
    } item_t;

    typedef struct packed {
        logic       spooled_up;
        gov_state_t gov_state;
        logic [THR_W-1:0] throttle_out;
    } result_t;

    // Move towards the target, rising by at most rate; a rate of zero is no limit.
    function automatic logic [THR_W-1:0] rise_limit(
        input logic [THR_W-1:0] cur,
        input logic [THR_W-1:0] tgt,
        input logic [THR_W-1:0] rate
    );
        logic [THR_W:0] sum;
        sum = {1'b0, cur} + {1'b0, rate};
        if ((rate != '0) && ({1'b0, tgt} > sum))
            return sum[THR_W-1:0];
        return tgt;
    endfunction

    // Slew limit in both directions.
    function automatic logic [THR_W-1:0] both_limit(
        input logic [THR_W-1:0] cur,
        input logic [THR_W-1:0] tgt,
        input logic [THR_W-1:0] rate
    );
        logic [THR_W:0]   sum;
        logic [THR_W-1:0] diff;
        sum  = {1'b0, cur} + {1'b0, rate};
        diff = cur - rate;
        if (rate != '0) begin
            if ({1'b0, tgt} > sum)
                return sum[THR_W-1:0];
            if ((cur > rate) && (tgt < diff))
                return diff;
        end
        return tgt;
    endfunction

    // Elapsed time is the wrapped difference taken as signed; negative never exceeds.
    function automatic logic elapsed_over(
        input logic [TIME_W-1:0] delta,
        input logic [TIME_W-1:0] limit
    );
        return !delta[TIME_W-1] && (delta > limit);
    endfunction

endpackage

>>> hw/rtl/tpg_cfg.sv
module tpg_cfg
    import tpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_THROTTLE_CEILING:  cfg_next.throttle_ceiling  = wr_data;
                REG_HANDOVER_THROTTLE: cfg_next.handover_throttle = wr_data[HOV_W-1:0];
                REG_STARTUP_RATE:      cfg_next.startup_rate      = wr_data;
                REG_SPOOLUP_RATE:      cfg_next.spoolup_rate      = wr_data;
                REG_TRACKING_RATE:     cfg_next.tracking_rate     = wr_data;
                REG_RECOVERY_RATE:     cfg_next.recovery_rate     = wr_data;
                REG_BAILOUT_RATE:      cfg_next.bailout_rate      = wr_data;
                REG_ZERO_TIMEOUT:
                    cfg_next.zero_throttle_timeout_ms = wr_data[TMO_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.throttle_ceiling         <= THROTTLE_CEILING_RST;
            cfg_reg.handover_throttle        <= HANDOVER_THROTTLE_RST;
            cfg_reg.startup_rate             <= '0;
            cfg_reg.spoolup_rate             <= '0;
            cfg_reg.tracking_rate            <= '0;
            cfg_reg.recovery_rate            <= '0;
            cfg_reg.bailout_rate             <= '0;
            cfg_reg.zero_throttle_timeout_ms <= ZERO_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/tpg_seq.sv
module tpg_seq
    import tpg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    gov_state_t        state_reg;
    gov_state_t        state_next;
    logic [TIME_W-1:0] entry_reg;
    logic [TIME_W-1:0] entry_next;
    logic [THR_W-1:0]  ramped_reg;
    logic [THR_W-1:0]  ramped_next;

    logic [THR_W-1:0]         thr;
    logic [THR_W-1:0]         ramp_val;
    logic [THR_W+BOOST_W-1:0] product;
    logic [THR_W:0]           boosted;
    logic [THR_W-1:0]         out_val;
    logic [TIME_W-1:0]        elapsed;
    logic                     auto_en;
    logic                     spooled;

    // Ramp and output datapath
    always_comb
    begin
        thr = (item.throttle_cmd < cfg.throttle_ceiling) ? item.throttle_cmd
                                                         : cfg.throttle_ceiling;
        case (state_reg)
            ST_IDLE:     ramp_val = rise_limit(ramped_reg, thr, cfg.startup_rate);
            ST_SPOOLUP:  ramp_val = rise_limit(ramped_reg, thr, cfg.spoolup_rate);
            ST_ACTIVE:   ramp_val = both_limit(ramped_reg, thr, cfg.tracking_rate);
            ST_AUTO:     ramp_val = rise_limit(ramped_reg, thr, cfg.tracking_rate);
            ST_BAILOUT:  ramp_val = rise_limit(ramped_reg, thr, cfg.bailout_rate);
            ST_RECOVERY: ramp_val = rise_limit(ramped_reg, thr, cfg.recovery_rate);
            default:     ramp_val = '0;
        endcase

        product = ramp_val * item.tail_boost;
        boosted = {1'b0, ramp_val} + {1'b0, product[THR_W+BOOST_W-1:BOOST_W]};

        if (!item.is_armed)
            out_val = '0;
        else if (state_reg == ST_ACTIVE)
            out_val = boosted[THR_W] ? OUT_MAX : boosted[THR_W-1:0];
        else
            out_val = ramp_val;

        ramped_next = item.is_armed ? ramp_val : ramped_reg;
    end

    // Next state
    always_comb
    begin
        elapsed    = item.now_ms - entry_reg;
        auto_en    = (AUTO_TIMEOUT_MS != '0) && (cfg.bailout_rate != '0);
        state_next = state_reg;
        entry_next = entry_reg;
        if (!item.is_armed)
        begin
            state_next = ST_OFF;
            entry_next = item.now_ms;
        end
        else
        begin
            unique case (state_reg)
                ST_OFF:
                begin
                    if (!item.throttle_is_low)
                        state_next = ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (item.throttle_is_low)
                        state_next = ST_OFF;
                    else if (thr > {1'b0, cfg.handover_throttle})
                        state_next = ST_SPOOLUP;
                end
                ST_SPOOLUP:
                begin
                    if (item.throttle_is_low)
                        state_next = ST_OFF;
                    else if (thr < {1'b0, cfg.handover_throttle})
                        state_next = ST_IDLE;
                    else if (out_val >= thr)
                        state_next = ST_ACTIVE;
                end
                ST_ACTIVE:
                begin
                    if (item.throttle_is_low)
                        state_next = ST_ZERO;
                    else if (thr < {1'b0, cfg.handover_throttle})
                    begin
                        if (auto_en && elapsed_over(elapsed, AUTO_MIN_ENTRY_MS))
                            state_next = ST_AUTO;
                        else
                            state_next = ST_IDLE;
                    end
                end
                ST_ZERO:
                begin
                    if (!item.throttle_is_low)
                        state_next = ST_RECOVERY;
                    else if (elapsed_over(elapsed,
                                          {{(TIME_W-TMO_W){1'b0}},
                                           cfg.zero_throttle_timeout_ms}))
                        state_next = ST_OFF;
                end
                ST_AUTO:
                begin
                    if (item.throttle_is_low)
                        state_next = ST_ZERO;
                    else if (thr > {1'b0, cfg.handover_throttle})
                        state_next = ST_BAILOUT;
                    else if (elapsed_over(elapsed, AUTO_TIMEOUT_MS))
                        state_next = ST_IDLE;
                end
                ST_BAILOUT:
                begin
                    if (item.throttle_is_low)
                        state_next = ST_ZERO;
                    else if (thr < {1'b0, cfg.handover_throttle})
                        state_next = ST_AUTO;
                    else if (out_val >= thr)
                        state_next = ST_ACTIVE;
                end
                ST_RECOVERY:
                begin
                    if (item.throttle_is_low)
                        state_next = ST_ZERO;
                    else if (thr < {1'b0, cfg.handover_throttle})
                        state_next = ST_IDLE;
                    else if (out_val >= thr)
                        state_next = ST_ACTIVE;
                end
                default:
                    state_next = ST_OFF;
            endcase
            // Every armed transition leads to a different state, so a change of state is
            // exactly when the entry time reloads.
            if (state_next != state_reg)
                entry_next = item.now_ms;
        end
    end

    // Outputs
    always_comb
    begin
        spooled = 1'b0;
        if (item.is_armed)
        begin
            unique case (state_next) inside
                ST_ACTIVE, ST_AUTO, ST_BAILOUT: spooled = 1'b1;
                ST_SPOOLUP, ST_RECOVERY:        spooled = out_val > SPOOL_THRESHOLD;
                default:                        spooled = 1'b0;
            endcase
        end
        result.throttle_out = out_val;
        result.gov_state    = state_next;
        result.spooled_up   = spooled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_OFF;
            entry_reg  <= '0;
            ramped_reg <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            entry_reg  <= entry_next;
            ramped_reg <= ramped_next;
        end
    end

    a_disarm_off: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.is_armed |=> state_reg == ST_OFF && entry_reg == $past(item.now_ms))
        else $error("disarm did not force the off state");

    a_disarm_keeps_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.is_armed |=> $stable(ramped_reg))
        else $error("disarm changed the ramped throttle");

    a_entry_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        step && state_next != state_reg |=> entry_reg == $past(item.now_ms))
        else $error("state change did not reload the entry time");

    a_off_clears_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.is_armed && (state_reg == ST_OFF || state_reg == ST_ZERO)
        |=> ramped_reg == '0)
        else $error("ramp not cleared in off or zero throttle");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg) && $stable(ramped_reg))
        else $error("sequencer state moved without an item");

endmodule

>>> hw/rtl/throttle_passthrough_governor.sv
// Throttle sequencer for a helicopter motor, one word in and one word out per control tick.
// A word accepted into the input register passes through the sequencer into the result register, which drives m_tdata.
// Throughput: one word per clock cycle while m_tready is high; the input and result
// registers let a new word enter while the previous result still waits on m_tready.
// Reset (rst_n low, asynchronous): sequencer off, entry time and ramp cleared,
// configuration registers back to their defaults, both stages empty.
module throttle_passthrough_governor
    import tpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input stream. s_tdata fields from bit 0: throttle_cmd[16:0], throttle_is_low[17],
    // is_armed[18], tail_boost[34:19], now_ms[66:35], unused bits[71:67].
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,

    // Result stream. m_tdata fields from bit 0: throttle_out[16:0], gov_state[19:17],
    // spooled_up[20], zero padding[23:21].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,

    // Configuration write channel: register index and value.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ITEM_W = $bits(item_t);
    localparam int RES_W  = $bits(result_t);

    // Input register stage: holds the accepted word until the sequencer consumes it.
    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;

    // Result register stage.
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    result_t res_comb;
    cfg_t    cfg;
    logic    advance;
    logic    step;
    logic    in_accept;

    // The result register can take a new value whenever it is empty or being drained.
    // The sequencer steps exactly when a word moves from the input to the result stage.
    assign advance   = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    // Configuration writes are always taken and unchecked; they must only arrive while the block is idle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        if (step)
            res_reg <= res_comb;
    end

    tpg_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tpg_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, res_reg};

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid)
        else $error("a processed word did not reach the result register");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("input word lost while the output was stalled");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(res_reg))
        else $error("pending result overwritten");

endmodule
